[rtl/brf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 10;
  localparam int unsigned CAP_W   = 10;

  // Default sizes.
  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned MAX_READ_DEF  = 64;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture the incoming word
    logic exec_simple;  // finish a one-result command and load its result
    logic start_read;   // load the byte counter of a read
    logic issue_read;   // read one byte at the head
    logic load_read;    // move the fetched byte into the output register
  } brf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             cnt_zero;
    logic             empty;
    logic             remain_nz;
    logic             rd_pend;
    logic             out_free;
  } brf_stat_t;

endpackage

`default_nettype wire

[rtl/byte_ring_fifo.sv]
// Flow: a one-result command is captured in the item registers and its result is then
// loaded into the output register once that register is free; a read is captured, loads its
// byte counter, then moves its bytes through the read stage into the output register, one
// byte per cycle while the output is taken. No new command is accepted until the last is done.
// Reset: rst_ni is asynchronous, active low; it empties the ring and sets capacity to 1023,
// or to MAX_SLOTS-1 if that is smaller. The byte store is not cleared; only bytes that were written are ever read back.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo #(
  parameter int unsigned MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_READ  = brf_pkg::MAX_READ_DEF
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // Capacity register write channel. Writing it empties the buffer.
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic [9:0]  cfg_data_i,
  // Command words.
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [15:0] s_axis_tdata,   // [7:0] write_byte, [14:8] read_count, [15] zero
  input  wire  logic [1:0]  s_axis_tuser,   // [1:0] command
  // Result words.
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [7:0] read_byte, [17:8] fill_level, [23:18] zero
  output logic [1:0]        m_axis_tuser,   // [1:0] status
  output logic              m_axis_tlast    // last word caused by one command
);
  import brf_pkg::*;

  brf_cmd_t          cmd;
  brf_stat_t         stat;
  logic              cfg_ready;
  logic [BYTE_W-1:0] out_byte;
  logic [FILL_W-1:0] out_fill;

  // The controller sequences each command: it captures the word, then either
  // finishes it with a single result or walks the read across the ring.
  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_ready_o (cfg_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the byte store, the ring pointers, the fill count,
  // the one-byte read stage and the output register.
  brf_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_READ  (MAX_READ)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .item_cmd_i   (s_axis_tuser),
    .item_byte_i  (s_axis_tdata[7:0]),
    .item_cnt_i   (s_axis_tdata[14:8]),
    .cfg_we_i     (cfg_valid_i && cfg_ready),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast),
    .out_fill_o   (out_fill)
  );

  assign cfg_ready_o  = cfg_ready;
  assign m_axis_tdata = {6'd0, out_fill, out_byte};

endmodule

`default_nettype wire

[rtl/brf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module brf_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  output logic                     cfg_ready_o,
  input  wire  brf_pkg::brf_stat_t stat_i,
  output brf_pkg::brf_cmd_t        cmd_o
);
  import brf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.item_cmd)
          CMD_WRITE, CMD_CLEAR: begin
            if (stat_i.out_free) begin
              cmd_o.exec_simple = 1'b1;
              state_d           = S_IDLE;
            end
          end
          CMD_READ: begin
            if (stat_i.cnt_zero || stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.exec_simple = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.start_read = 1'b1;
              state_d          = S_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd_o.issue_read = stat_i.remain_nz && (!stat_i.rd_pend || stat_i.out_free);
        cmd_o.load_read  = stat_i.rd_pend && stat_i.out_free;
        if (!stat_i.remain_nz && (!stat_i.rd_pend || stat_i.out_free)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/brf_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module brf_dpath #(
  parameter int unsigned MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_READ  = brf_pkg::MAX_READ_DEF
) (
  input  wire                logic                          clk_i,
  input  wire                logic                          rst_ni,
  input  wire                brf_pkg::brf_cmd_t             cmd_i,
  output brf_pkg::brf_stat_t                                stat_o,
  input  wire                logic [brf_pkg::CMD_W-1:0]     item_cmd_i,
  input  wire                logic [brf_pkg::BYTE_W-1:0]    item_byte_i,
  input  wire                logic [brf_pkg::COUNT_W-1:0]   item_cnt_i,
  input  wire                logic                          cfg_we_i,
  input  wire                logic [brf_pkg::CAP_W-1:0]     cfg_data_i,
  output logic                                              out_valid_o,
  input  wire                logic                          out_ready_i,
  output logic [brf_pkg::STAT_W-1:0]                        out_status_o,
  output logic [brf_pkg::BYTE_W-1:0]                        out_byte_o,
  output logic                                              out_last_o,
  output logic [brf_pkg::FILL_W-1:0]                        out_fill_o
);
  import brf_pkg::*;

  localparam int unsigned IdxW     = $clog2(MAX_SLOTS);
  localparam int unsigned CapLimit = (MAX_SLOTS - 1 > 1023) ? 1023 : MAX_SLOTS - 1;
  localparam logic [CAP_W-1:0]   CapLimitL = CAP_W'(CapLimit);
  localparam logic [COUNT_W-1:0] ReadMax   = COUNT_W'(MAX_READ);

  logic [BYTE_W-1:0]  byte_store_q [MAX_SLOTS];

  logic [CMD_W-1:0]   item_cmd_q;
  logic [BYTE_W-1:0]  item_byte_q;
  logic [COUNT_W-1:0] item_cnt_q;

  logic [CAP_W-1:0]   usable_q, usable_d;
  logic [IdxW-1:0]    last_idx_q, last_idx_d;
  logic [IdxW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]  held_q, held_d;
  logic [COUNT_W-1:0] remain_q, remain_d;

  logic               rd_pend_q, rd_pend_d;
  logic [BYTE_W-1:0]  rdata_q;
  logic [FILL_W-1:0]  rd_fill_q;
  logic               rd_last_q;

  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_status_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;
  logic [FILL_W-1:0]  out_fill_q;

  logic               full, out_free, mem_we;
  logic [CAP_W-1:0]   cap_nz;
  logic [COUNT_W-1:0] cnt_sat, read_n;
  logic [STAT_W-1:0]  simple_status;
  logic [FILL_W-1:0]  simple_fill;

  assign full     = (held_q >= usable_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign mem_we   = cmd_i.exec_simple && (item_cmd_q == CMD_WRITE) && !full;

  assign stat_o.item_cmd  = item_cmd_q;
  assign stat_o.cnt_zero  = (item_cnt_q == '0);
  assign stat_o.empty     = (held_q == '0);
  assign stat_o.remain_nz = (remain_q != '0);
  assign stat_o.rd_pend   = rd_pend_q;
  assign stat_o.out_free  = out_free;

  // Capacity is clamped to 1..slots-1 once, when it is written.
  assign cap_nz = (cfg_data_i == '0) ? CAP_W'(1) : cfg_data_i;

  // A read returns the smaller of the saturated count and the bytes held.
  assign cnt_sat = (item_cnt_q > ReadMax) ? ReadMax : item_cnt_q;
  assign read_n  = (held_q < FILL_W'(cnt_sat)) ? held_q[COUNT_W-1:0] : cnt_sat;

  always_comb begin
    unique case (item_cmd_q)
      CMD_WRITE: begin
        simple_status = full ? ST_FULL : ST_OK;
        simple_fill   = full ? held_q : held_q + FILL_W'(1);
      end
      CMD_READ: begin
        simple_status = (item_cnt_q == '0) ? ST_ZERO : ST_EMPTY;
        simple_fill   = held_q;
      end
      CMD_CLEAR: begin
        simple_status = ST_OK;
        simple_fill   = '0;
      end
      default: begin
        simple_status = ST_OK;
        simple_fill   = held_q;
      end
    endcase
  end

  always_comb begin
    usable_d   = usable_q;
    last_idx_d = last_idx_q;
    head_d     = head_q;
    tail_d     = tail_q;
    held_d     = held_q;
    remain_d   = remain_q;
    rd_pend_d  = rd_pend_q;
    priority if (cfg_we_i) begin
      usable_d   = (cap_nz > CapLimitL) ? CapLimitL : cap_nz;
      last_idx_d = IdxW'(usable_d);
      head_d     = '0;
      tail_d     = '0;
      held_d     = '0;
    end else if (cmd_i.exec_simple && (item_cmd_q == CMD_CLEAR)) begin
      head_d = '0;
      tail_d = '0;
      held_d = '0;
    end else if (mem_we) begin
      tail_d = (tail_q == last_idx_q) ? '0 : tail_q + IdxW'(1);
      held_d = held_q + FILL_W'(1);
    end else if (cmd_i.start_read) begin
      remain_d = read_n;
    end else if (cmd_i.issue_read) begin
      head_d   = (head_q == last_idx_q) ? '0 : head_q + IdxW'(1);
      held_d   = held_q - FILL_W'(1);
      remain_d = remain_q - COUNT_W'(1);
    end
    if (cmd_i.issue_read) begin
      rd_pend_d = 1'b1;
    end else if (cmd_i.load_read) begin
      rd_pend_d = 1'b0;
    end
  end

  always_comb begin
    if (cmd_i.exec_simple || cmd_i.load_read) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q    <= (CAP_RESET > CapLimitL) ? CapLimitL : CAP_RESET;
      last_idx_q  <= IdxW'((CAP_RESET > CapLimitL) ? CapLimitL : CAP_RESET);
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      remain_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      usable_q    <= usable_d;
      last_idx_q  <= last_idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      held_q      <= held_d;
      remain_q    <= remain_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and the byte store carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_cmd_q  <= item_cmd_i;
      item_byte_q <= item_byte_i;
      item_cnt_q  <= item_cnt_i;
    end
    if (mem_we) begin
      byte_store_q[tail_q] <= item_byte_q;
    end
    if (cmd_i.issue_read) begin
      rdata_q   <= byte_store_q[head_q];
      rd_fill_q <= held_q - FILL_W'(1);
      rd_last_q <= (remain_q == COUNT_W'(1));
    end
    if (cmd_i.exec_simple) begin
      out_status_q <= simple_status;
      out_byte_q   <= '0;
      out_last_q   <= 1'b1;
      out_fill_q   <= simple_fill;
    end else if (cmd_i.load_read) begin
      out_status_q <= ST_OK;
      out_byte_q   <= rdata_q;
      out_last_q   <= rd_last_q;
      out_fill_q   <= rd_fill_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_fill_o   = out_fill_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= usable_q)
    else $error("fill level exceeds capacity");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= last_idx_q) && (tail_q <= last_idx_q))
    else $error("ring pointer beyond last slot");

  a_issue_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_read |-> (held_q != '0))
    else $error("byte read from an empty ring");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec_simple || cmd_i.load_read) |-> out_free)
    else $error("output register overwritten");

  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec_simple && cmd_i.load_read))
    else $error("two results loaded at once");

endmodule

`default_nettype wire
